>>> hw/rtl/lzss_pkg.sv
// Shared types and constants for the LZSS decompressor.
package lzss_pkg;

	// window geometry
	localparam int WIN_AW = 12;
	localparam int WIN_DEPTH = 1 << WIN_AW;
	localparam int FILL_W = WIN_AW + 1;
	localparam logic [WIN_AW-1:0] WIN_START = 12'hFF0;

	// match token layout
	localparam int LEN_W = 5;
	localparam int MATCH_MIN = 3;
	localparam logic [8:0] FLAG_MARK = 9'h100;

	typedef struct packed {
		logic [7:0] in_byte;
		logic in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic byte_valid;
		logic stream_done;
		logic stream_error;
		logic last_of_run;
	} out_word_t;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_TOKEN,
		PH_MATCH2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_MATCH,
		CMD_STATUS
	} cmd_kind_t;

	// one command from the parser to the copy engine
	typedef struct packed {
		cmd_kind_t kind;
		logic [WIN_AW-1:0] data;
		logic [LEN_W-1:0] len;
		logic status_after;
		logic status_err;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LIT,
		BK_READ,
		BK_EMIT,
		BK_STATUS
	} back_state_t;

endpackage

>>> hw/rtl/lzss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/lzss_front.sv
// Token parser: accepts compressed words, tracks flags and limits, issues commands.
module lzss_front
	import lzss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic [31:0] limit_q;
	logic [31:0] count_q;
	logic [8:0]  flags_q;
	logic [7:0]  low_q;
	phase_t      phase_q;
	logic        finished_q;

	logic [31:0] count_d;
	logic [8:0]  flags_d;
	logic [7:0]  low_d;
	phase_t      phase_d;
	logic        finished_d;

	logic        accept;
	logic        full;
	logic [LEN_W-1:0] mlen;
	logic [32:0] msum;
	logic [8:0]  flags_sh;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign full = (count_q >= limit_q);
	assign mlen = LEN_W'(in_data.in_byte[3:0]) + LEN_W'(MATCH_MIN);
	assign msum = {1'b0, count_q} + 33'(mlen);
	assign flags_sh = flags_q >> 1;

	// classify the accepted word and pick the next parser state
	always_comb begin
		count_d = count_q;
		flags_d = flags_q;
		low_d = low_q;
		phase_d = phase_q;
		finished_d = finished_q;
		q_push = 1'b0;
		q_cmd.kind = CMD_STATUS;
		q_cmd.data = {4'h0, in_data.in_byte};
		q_cmd.len = mlen;
		q_cmd.status_after = 1'b0;
		q_cmd.status_err = 1'b0;
		if (accept) begin
			if (finished_q) begin
				// swallow until the last word
				if (in_data.in_last) begin
					finished_d = 1'b0;
					count_d = '0;
					flags_d = '0;
					low_d = '0;
					phase_d = PH_FLAG;
				end
			end else begin
				unique case (phase_q)
					PH_FLAG: begin
						if (full || in_data.in_last) begin
							q_push = 1'b1;
							q_cmd.kind = CMD_STATUS;
							q_cmd.status_err = !full;
						end else begin
							flags_d = {1'b0, in_data.in_byte} | FLAG_MARK;
							phase_d = PH_TOKEN;
						end
					end
					PH_TOKEN: begin
						if (flags_q[0]) begin
							q_push = 1'b1;
							if (full) begin
								q_cmd.kind = CMD_STATUS;
								q_cmd.status_err = 1'b1;
							end else begin
								q_cmd.kind = CMD_LIT;
								q_cmd.status_after = in_data.in_last;
								count_d = count_q + 32'd1;
								flags_d = flags_sh;
								phase_d = (flags_sh > 9'd1) ? PH_TOKEN : PH_FLAG;
							end
						end else if (in_data.in_last) begin
							q_push = 1'b1;
							q_cmd.kind = CMD_STATUS;
							q_cmd.status_err = 1'b1;
						end else begin
							low_d = in_data.in_byte;
							phase_d = PH_MATCH2;
						end
					end
					PH_MATCH2: begin
						q_push = 1'b1;
						if (msum > {1'b0, limit_q}) begin
							q_cmd.kind = CMD_STATUS;
							q_cmd.status_err = 1'b1;
						end else begin
							q_cmd.kind = CMD_MATCH;
							q_cmd.data = {in_data.in_byte[7:4], low_q};
							q_cmd.status_after = in_data.in_last;
							count_d = msum[31:0];
							flags_d = flags_sh;
							phase_d = (flags_sh > 9'd1) ? PH_TOKEN : PH_FLAG;
						end
					end
					default: begin
						phase_d = PH_FLAG;
					end
				endcase
				// end of stream: reset on the last word, otherwise wait for it
				if (q_push && (q_cmd.kind == CMD_STATUS || q_cmd.status_after)) begin
					if (in_data.in_last) begin
						count_d = '0;
						flags_d = '0;
						low_d = '0;
						phase_d = PH_FLAG;
					end else begin
						finished_d = 1'b1;
					end
				end
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flags_q <= '0;
			low_q <= '0;
			phase_q <= PH_FLAG;
			finished_q <= 1'b0;
		end else begin
			count_q <= count_d;
			flags_q <= flags_d;
			low_q <= low_d;
			phase_q <= phase_d;
			finished_q <= finished_d;
		end
	end

	// output limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

endmodule

>>> hw/rtl/lzss_cmd_queue.sv
// Small command FIFO between the parser and the copy engine.
module lzss_cmd_queue
	import lzss_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_cmd = entry_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/lzss_back.sv
// Copy engine: runs commands through the history window and drives the output register.
module lzss_back
	import lzss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  cmd_t      q_cmd,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_DEPTH);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [WIN_AW-1:0] wpos_q;
	logic [FILL_W-1:0] fill_q;
	logic [WIN_AW-1:0] src_q;
	logic [LEN_W-1:0]  len_q;
	logic              stat_after_q;
	logic              stat_err_q;
	logic              rd_ok_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic              load_ok;
	logic              emit;
	logic              emit_byte;
	logic              stream_reset;
	logic              ram_re;
	logic [7:0]        ram_rdata;
	logic [WIN_AW-1:0] src_dist;
	logic              src_ok;
	out_word_t         emit_word;

	assign load_ok = !out_valid_q || out_ready;
	assign src_dist = src_q - WIN_START;
	assign src_ok = ({1'b0, src_dist} < fill_q);

	lzss_ram #(
		.WIDTH(8),
		.DEPTH(WIN_DEPTH)
	) u_window (
		.clk(clk),
		.we(emit_byte),
		.waddr(wpos_q),
		.wdata(emit_word.out_byte),
		.re(ram_re),
		.raddr(src_q),
		.rdata(ram_rdata)
	);

	// sequence commands and build output words
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		emit = 1'b0;
		emit_byte = 1'b0;
		stream_reset = 1'b0;
		ram_re = 1'b0;
		emit_word = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (q_cmd.kind)
						CMD_LIT: state_d = BK_LIT;
						CMD_MATCH: state_d = BK_READ;
						CMD_STATUS: state_d = BK_STATUS;
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_LIT: begin
				emit_word.out_byte = src_q[7:0];
				emit_word.byte_valid = 1'b1;
				emit_word.last_of_run = !stat_after_q;
				if (load_ok) begin
					emit = 1'b1;
					emit_byte = 1'b1;
					state_d = stat_after_q ? BK_STATUS : BK_IDLE;
				end
			end
			BK_READ: begin
				ram_re = 1'b1;
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				emit_word.out_byte = rd_ok_q ? ram_rdata : 8'h00;
				emit_word.byte_valid = 1'b1;
				emit_word.last_of_run = (len_q == LEN_W'(1)) && !stat_after_q;
				if (load_ok) begin
					emit = 1'b1;
					emit_byte = 1'b1;
					if (len_q != LEN_W'(1)) begin
						state_d = BK_READ;
					end else begin
						state_d = stat_after_q ? BK_STATUS : BK_IDLE;
					end
				end
			end
			BK_STATUS: begin
				emit_word.stream_done = 1'b1;
				emit_word.stream_error = stat_err_q;
				emit_word.last_of_run = 1'b1;
				if (load_ok) begin
					emit = 1'b1;
					stream_reset = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// state register, window position and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			wpos_q <= WIN_START;
			fill_q <= '0;
		end else begin
			state_q <= state_d;
			if (stream_reset) begin
				wpos_q <= WIN_START;
				fill_q <= '0;
			end else if (emit_byte) begin
				wpos_q <= wpos_q + WIN_AW'(1);
				if (fill_q != FILL_MAX) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// latch the current command and step through a match
	always_ff @(posedge clk) begin
		if (q_pop) begin
			src_q <= q_cmd.data;
			len_q <= q_cmd.len;
			stat_after_q <= q_cmd.status_after;
			stat_err_q <= q_cmd.status_err;
		end else if (emit_byte) begin
			src_q <= src_q + WIN_AW'(1);
			len_q <= len_q - LEN_W'(1);
		end
		// entries not yet written in this stream read as zero
		if (ram_re) begin
			rd_ok_q <= src_ok;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q <= emit_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_word_q;

endmodule

>>> hw/rtl/lzss_decompressor_top.sv
// Top level of the LZSS decompressor: parser, command queue and copy engine.
//
// Channel   Signals                        Direction  Carries
// in        in_valid, in_ready, in_data    input      one compressed byte and last mark
// out       out_valid, out_ready, out_data output     one decoded byte or stream status
// cfg       cfg_we, cfg_wdata              input      output limit register
//
// The parser takes one word per cycle while the command queue has room; flag
// and first match bytes make no command. The copy engine sets the rate: each
// command is popped from idle, then a literal is emitted, a match alternates a
// window read with write and emit per byte (registered read port), and a
// status is emitted. The window is not cleared: a fill count masks entries not
// yet written in the stream, so reset has no clearing pass. A stalled output
// holds the engine, and a full queue drops in_ready.
module lzss_decompressor_top
	import lzss_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t head_cmd;

	lzss_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(push_cmd)
	);

	lzss_cmd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.head_cmd(head_cmd),
		.empty(q_empty)
	);

	lzss_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(head_cmd),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
